### rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the system-call trampoline watcher.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int PENDING_DEPTH_DEF = 4;
	localparam int PATCH_ENTRIES_DEF = 63;

	localparam int MAP_DEPTH   = 3072;
	localparam int MAP_AW      = 12;
	localparam int PATCH_DEPTH = 64;
	localparam int PATCH_AW    = 6;
	localparam int MAX_OUT     = 4;

	localparam logic [5:0] MAP_EMPTY = 6'h3f;
	localparam logic [5:0] IDX_MAX   = 6'd63;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_BASE = 2'd1,
		OP_JUMP = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_HIT    = 3'd1,
		KIND_TAIL   = 3'd2,
		KIND_STORED = 3'd3,
		KIND_REJECT = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MAP_WAIT,
		ST_PATCH_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_MOVE,
		ST_PUT
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic        call_head;
		logic        tail_queued;
		logic        tail_dropped;
		logic        call_tail;
		logic        overwrote;
		logic [5:0]  patch_index;
		logic [31:0] patch_code;
		logic [1:0]  pending_slot;
	} res_t;

	// one pending tail entry
	typedef struct packed {
		logic [31:0] ret_addr;
		logic [31:0] stack;
		logic [5:0]  idx;
	} pend_t;

	// patch store word: {tail, head, code}
	localparam int PATCH_W = 34;
	localparam int PEND_W  = $bits(pend_t);

endpackage

### rtl/syscall_trap_patch_dispatch.sv
// ----------------------------------------------------------------------------
// syscall_trap_patch_dispatch
// Watches emulated ARM events for the system-call trampoline, looks up
// patches and dispatches head and tail hooks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | op, syscall_code, has_head,
//          |           |                    | has_tail, offset, link_reg,
//          |           |                    | stack_ptr, prog_counter
//  out     | output    | out_valid/out_stall| kind, call_head, tail_queued,
//          |           |                    | tail_dropped, call_tail, overwrote,
//          |           |                    | patch_index, patch_code,
//          |           |                    | pending_slot, slow_path, last
//
// One item at a time under a small sequencer. A tick over the pending entries
// first pre-counts matches, then removes and reports the matched entries, all
// through the one pending-entry compare unit and the pending RAM.
// After reset a clearing pass writes all 3072 map entries with in_stall high.
// Results leave through an output register; out_stall holds the sequencer in
// its emit state, and a new item is taken while a result waits.
// ----------------------------------------------------------------------------
module syscall_trap_patch_dispatch import stp_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
	parameter int PATCH_ENTRIES = PATCH_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [31:0]        syscall_code,
	input  logic               has_head,
	input  logic               has_tail,
	input  logic signed [12:0] offset,
	input  logic [31:0]        link_reg,
	input  logic [31:0]        stack_ptr,
	input  logic [31:0]        prog_counter,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic               call_head,
	output logic               tail_queued,
	output logic               tail_dropped,
	output logic               call_tail,
	output logic               overwrote,
	output logic [5:0]         patch_index,
	output logic [31:0]        patch_code,
	output logic [1:0]         pending_slot,
	output logic               slow_path,
	output logic               last
);

	localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam logic [5:0] PATCH_LIMIT =
		(PATCH_ENTRIES < 63) ? 6'(PATCH_ENTRIES) : IDX_MAX;
	localparam logic [PCW-1:0] PEND_FULL = PCW'(PENDING_DEPTH);
	localparam logic [MAP_AW-1:0] MAP_LAST = MAP_AW'(MAP_DEPTH - 1);

	state_t state_q, state_d;

	// latched item
	op_t                op_q;
	logic [31:0]        code_q;
	logic               head_q;
	logic               tail_q;
	logic signed [12:0] off_q;
	logic [31:0]        lr_q;
	logic [31:0]        sp_q;
	logic [31:0]        pc_q;

	// block state
	logic [1:0]         tsel_q;
	logic [1:0]         cd_q;
	logic [5:0]         pcnt_q;
	logic [PCW-1:0]     pend_cnt_q;
	logic [MAP_AW-1:0]  clr_q;

	// tick scan
	logic [PCW-1:0]     scan_q;
	logic [PCW-1:0]     mcnt_q;
	logic [PCW-1:0]     final_q;
	logic [2:0]         hcnt_q;
	logic [2:0]         emit_q;
	logic               remove_q;

	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;
	logic               out_slow_q;
	logic               out_last_q;

	// RAM ports
	logic                map_we;
	logic [MAP_AW-1:0]   map_wa;
	logic [5:0]          map_wd;
	logic [MAP_AW-1:0]   map_ra;
	logic [5:0]          map_rd;
	logic                patch_we;
	logic [PATCH_AW-1:0] patch_wa;
	logic [PATCH_W-1:0]  patch_wd;
	logic [PATCH_AW-1:0] patch_ra;
	logic [PATCH_W-1:0]  patch_rd;
	logic                pend_we;
	logic [PAW-1:0]      pend_wa;
	pend_t               pend_wd;
	logic [PAW-1:0]      pend_ra;
	logic [PEND_W-1:0]   pend_rd_raw;
	pend_t               pend_rd;

	logic                accept;
	logic                out_load;
	logic                hit;
	logic [17:0]         add_tbl;
	logic                add_ok;
	logic [MAP_AW-1:0]   add_key;
	logic                jump_ok;
	logic [MAP_AW-1:0]   jump_key;
	logic                map_empty;
	logic                patch_room;
	logic [PCW-1:0]      mcnt_nxt;
	logic                scan_end;
	logic [2:0]          hits_cap;
	logic                more_emit;
	logic                res_last;
	logic                res_slow;
	logic [1:0]          base_tsel;
	res_t                res_dec;
	res_t                res_tail;

	stp_ram #(.WIDTH(6), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_addr (map_wa),
		.wr_data (map_wd),
		.rd_addr (map_ra),
		.rd_data (map_rd)
	);

	stp_ram #(.WIDTH(PATCH_W), .DEPTH(PATCH_DEPTH)) u_patch_ram (
		.clk     (clk),
		.wr_en   (patch_we),
		.wr_addr (patch_wa),
		.wr_data (patch_wd),
		.rd_addr (patch_ra),
		.rd_data (patch_rd)
	);

	stp_ram #(.WIDTH(PEND_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk     (clk),
		.wr_en   (pend_we),
		.wr_addr (pend_wa),
		.wr_data (pend_wd),
		.rd_addr (pend_ra),
		.rd_data (pend_rd_raw)
	);

	assign pend_rd = pend_t'(pend_rd_raw);

	stp_match u_match (
		.entry (pend_rd),
		.pc    (pc_q),
		.sp    (sp_q),
		.hit   (hit)
	);

	// key decode: table number 1..3 in bits 14 up, entry in bits 11..2
	assign add_tbl  = code_q[31:14] - 18'd1;
	assign add_ok   = (add_tbl < 18'd3);
	assign add_key  = {add_tbl[1:0], code_q[11:2]};
	assign jump_ok  = (cd_q == 2'd1) && !off_q[12] && (off_q[1:0] == 2'b00) &&
		(tsel_q != 2'd0);
	assign jump_key = {tsel_q - 2'd1, off_q[11:2]};
	assign map_ra   = (op_q == OP_ADD) ? add_key : jump_key;

	// base load at -4, -8 or -12 selects table 1..3, anything else none
	assign base_tsel = (off_q == -13'sd4)  ? 2'd1 :
		(off_q == -13'sd8)  ? 2'd2 :
		(off_q == -13'sd12) ? 2'd3 : 2'd0;

	assign map_empty  = (map_rd == MAP_EMPTY);
	assign patch_room = (pcnt_q < PATCH_LIMIT);

	assign mcnt_nxt = mcnt_q + PCW'(hit);
	assign scan_end = (scan_q + PCW'(1) == pend_cnt_q);
	assign hits_cap = (32'(mcnt_nxt) >= MAX_OUT) ? 3'(MAX_OUT) : 3'(mcnt_nxt);
	assign more_emit = (op_q == OP_TICK) && remove_q && (emit_q + 3'd1 != hcnt_q);

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign out_load = (state_q == ST_PUT) && (!out_valid_q || !out_stall);

	assign res_last = !more_emit;
	assign res_slow = (cd_q != 2'd0) ||
		(((op_q == OP_TICK) ? final_q : pend_cnt_q) != '0);

	// starting result of a step, and the report for a matched tail entry
	always_comb begin
		res_dec = '0;
		if (op_q == OP_ADD && !add_ok) res_dec.kind = KIND_REJECT;
		res_tail              = '0;
		res_tail.kind         = KIND_TAIL;
		res_tail.patch_index  = pend_rd.idx;
		res_tail.pending_slot = 2'(scan_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == MAP_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (op_q)
					OP_ADD:  state_d = add_ok ? ST_MAP_WAIT : ST_PUT;
					OP_BASE: state_d = ST_PUT;
					OP_JUMP: state_d = jump_ok ? ST_MAP_WAIT : ST_PUT;
					OP_TICK: state_d = (pend_cnt_q == '0) ? ST_PUT : ST_SCAN_RD;
					default: state_d = ST_PUT;
				endcase
			end
			ST_MAP_WAIT: begin
				if (op_q == OP_JUMP && !map_empty) state_d = ST_PATCH_WAIT;
				else state_d = ST_PUT;
			end
			ST_PATCH_WAIT: state_d = ST_PUT;
			ST_SCAN_RD:    state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (remove_q) begin
					state_d = hit ? ST_MOVE : ST_SCAN_RD;
				end else if (scan_end) begin
					state_d = (hits_cap == 3'd0) ? ST_PUT : ST_SCAN_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MOVE: state_d = ST_PUT;
			ST_PUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = more_emit ? ST_SCAN_RD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: stall and RAM controls
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		map_we   = 1'b0;
		map_wa   = add_key;
		map_wd   = pcnt_q;
		patch_we = 1'b0;
		patch_wa = map_empty ? pcnt_q : map_rd;
		patch_wd = {tail_q, head_q, code_q};
		patch_ra = pend_rd.idx;
		pend_we  = 1'b0;
		pend_wa  = pend_cnt_q[PAW-1:0];
		pend_wd  = '{ret_addr: {lr_q[31:1], 1'b0}, stack: sp_q, idx: res_q.patch_index};
		pend_ra  = scan_q[PAW-1:0];
		case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = MAP_EMPTY;
			end
			ST_MAP_WAIT: begin
				patch_ra = map_rd;
				if (op_q == OP_ADD) begin
					map_we   = map_empty && patch_room;
					patch_we = !map_empty || patch_room;
				end
			end
			ST_PATCH_WAIT: begin
				pend_we = patch_rd[33] && (pend_cnt_q < PEND_FULL);
			end
			ST_SCAN_CMP: begin
				// fetch the last entry to fill a freed slot
				pend_ra = PAW'(pend_cnt_q - PCW'(1));
			end
			ST_MOVE: begin
				pend_we = 1'b1;
				pend_wa = scan_q[PAW-1:0];
				pend_wd = pend_rd;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			tsel_q     <= 2'd0;
			cd_q       <= 2'd0;
			pcnt_q     <= 6'd0;
			pend_cnt_q <= '0;
			remove_q   <= 1'b0;
			emit_q     <= 3'd0;
			hcnt_q     <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + MAP_AW'(1);
				ST_DECODE: begin
					remove_q <= 1'b0;
					emit_q   <= 3'd0;
					hcnt_q   <= 3'd0;
					if (op_q == OP_BASE) begin
						tsel_q <= base_tsel;
						cd_q   <= (base_tsel != 2'd0) ? 2'd2 : 2'd0;
					end else if (op_q == OP_TICK && cd_q != 2'd0) begin
						cd_q <= cd_q - 2'd1;
					end
				end
				ST_MAP_WAIT: begin
					if (op_q == OP_ADD && map_empty && patch_room) pcnt_q <= pcnt_q + 6'd1;
				end
				ST_PATCH_WAIT: begin
					if (pend_we) pend_cnt_q <= pend_cnt_q + PCW'(1);
				end
				ST_SCAN_CMP: begin
					if (!remove_q && scan_end) begin
						hcnt_q   <= hits_cap;
						remove_q <= (hits_cap != 3'd0);
					end
				end
				ST_MOVE: pend_cnt_q <= pend_cnt_q - PCW'(1);
				ST_PUT: begin
					if (out_load && op_q == OP_TICK && remove_q) emit_q <= emit_q + 3'd1;
				end
				default: begin
				end
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item, scan and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			code_q <= syscall_code;
			head_q <= has_head;
			tail_q <= has_tail;
			off_q  <= offset;
			lr_q   <= link_reg;
			sp_q   <= stack_ptr;
			pc_q   <= prog_counter;
		end
		case (state_q)
			ST_DECODE: begin
				res_q   <= res_dec;
				scan_q  <= '0;
				mcnt_q  <= '0;
				final_q <= '0;
			end
			ST_MAP_WAIT: begin
				if (op_q == OP_ADD) begin
					if (!map_empty) begin
						res_q.kind        <= KIND_STORED;
						res_q.overwrote   <= 1'b1;
						res_q.patch_index <= map_rd;
						res_q.patch_code  <= code_q;
					end else if (patch_room) begin
						res_q.kind        <= KIND_STORED;
						res_q.patch_index <= pcnt_q;
						res_q.patch_code  <= code_q;
					end else begin
						res_q.kind <= KIND_REJECT;
					end
				end else if (!map_empty) begin
					res_q.patch_index <= map_rd;
				end
			end
			ST_PATCH_WAIT: begin
				res_q.kind       <= KIND_HIT;
				res_q.call_head  <= patch_rd[32];
				res_q.patch_code <= patch_rd[31:0];
				if (patch_rd[33]) begin
					if (pend_cnt_q < PEND_FULL) begin
						res_q.tail_queued  <= 1'b1;
						res_q.pending_slot <= 2'(pend_cnt_q);
					end else begin
						res_q.tail_dropped <= 1'b1;
					end
				end
			end
			ST_SCAN_CMP: begin
				if (remove_q) begin
					if (hit) begin
						res_q <= res_tail;
					end else begin
						scan_q <= scan_q + PCW'(1);
					end
				end else begin
					mcnt_q <= mcnt_nxt;
					if (scan_end) begin
						scan_q  <= '0;
						final_q <= pend_cnt_q - PCW'(hits_cap);
					end else begin
						scan_q <= scan_q + PCW'(1);
					end
				end
			end
			ST_MOVE: begin
				res_q.call_tail  <= patch_rd[33];
				res_q.patch_code <= patch_rd[31:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q      <= res_q;
			out_slow_q <= res_slow;
			out_last_q <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign call_head    = out_q.call_head;
	assign tail_queued  = out_q.tail_queued;
	assign tail_dropped = out_q.tail_dropped;
	assign call_tail    = out_q.call_tail;
	assign overwrote    = out_q.overwrote;
	assign patch_index  = out_q.patch_index;
	assign patch_code   = out_q.patch_code;
	assign pending_slot = out_q.pending_slot;
	assign slow_path    = out_slow_q;
	assign last         = out_last_q;

endmodule

### rtl/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/stp_match.sv
// ----------------------------------------------------------------------------
// stp_match
// Shared compare unit: checks one pending entry against the current pc and sp.
// ----------------------------------------------------------------------------
module stp_match import stp_pkg::*; (
	input  pend_t       entry,
	input  logic [31:0] pc,
	input  logic [31:0] sp,
	output logic        hit
);

	logic ret_eq;
	logic sp_eq;

	assign ret_eq = (entry.ret_addr == pc);
	assign sp_eq  = (entry.stack == sp);
	assign hit    = ret_eq & sp_eq;

endmodule
